// ===== hdl/stack_machine_execute_unit_assert.svh =====
// Assertion macros shared by the checker of the stack machine execute unit.
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define SMX_ASSERT_NOW(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("stack machine check failed");

// Condition holds in the cycle after the trigger.
`define SMX_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("stack machine check failed");

`endif

// ===== hdl/smx_pkg.sv =====
// Shared constants, codes and control structures of the stack machine execute unit.
package smx_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int VAR_COUNT   = 16;
    localparam int DATA_W      = 32;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SA_W        = $clog2(STACK_DEPTH);
    localparam int VI_W        = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    typedef enum logic [4:0] {
        OP_PUSH  = 5'd0,  OP_ADD   = 5'd1,  OP_SUB  = 5'd2,  OP_MUL  = 5'd3,
        OP_DIV   = 5'd4,  OP_MOD   = 5'd5,  OP_NEG  = 5'd6,  OP_PRINT = 5'd7,
        OP_DUP   = 5'd8,  OP_DROP  = 5'd9,  OP_SWAP = 5'd10, OP_ROT  = 5'd11,
        OP_SET   = 5'd12, OP_FETCH = 5'd13, OP_STORE = 5'd14, OP_LT  = 5'd15,
        OP_GT    = 5'd16, OP_LE    = 5'd17, OP_GE   = 5'd18, OP_EQ   = 5'd19,
        OP_NE    = 5'd20, OP_AND   = 5'd21, OP_OR   = 5'd22, OP_NOT  = 5'd23
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_UNDER  = 3'd1,
        ST_OVER   = 3'd2,
        ST_DIVZ   = 3'd3,
        ST_EXISTS = 3'd4,
        ST_UNDEF  = 3'd5,
        ST_BADIDX = 3'd6,
        ST_BADOP  = 3'd7
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       check;
        logic       rd_en;
        logic [1:0] rd_k;
        logic       cap_en;
        logic [1:0] cap_k;
        logic       exec;
        logic       div_start;
        logic       div_take;
        logic       wr_en;
        logic [1:0] wr_k;
        logic       load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       pre_err;
        logic [1:0] need;
        logic       div_go;
        logic       div_done;
        logic [1:0] nw;
    } dp_stat_t;

    // Number of stack entries an operation reads.
    function automatic logic [1:0] op_need(input logic [4:0] op);
        logic [1:0] n;
        unique case (op)
            OP_PUSH:                                   n = 2'd0;
            OP_NEG, OP_PRINT, OP_DUP, OP_DROP,
            OP_FETCH, OP_NOT:                          n = 2'd1;
            OP_ROT:                                    n = 2'd3;
            default:                                   n = 2'd2;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/smx_in_if.sv =====
// Input channel of the stack machine execute unit: opcode and literal.
interface smx_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  opcode;
    logic [31:0] literal;

    modport source (output valid, output opcode, output literal, input ready);
    modport sink (input valid, input opcode, input literal, output ready);
endinterface

// ===== hdl/smx_out_if.sv =====
// Result channel of the stack machine execute unit.
interface smx_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        print_valid;
    logic [31:0] print_value;
    logic [6:0]  stack_depth;

    modport source (output valid, output status, output print_valid, output print_value,
                    output stack_depth, input ready);
    modport sink (input valid, input status, input print_valid, input print_value,
                  input stack_depth, output ready);
endinterface

// ===== hdl/smx_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating towards zero.
module smx_div
    import smx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient,
    output logic [DATA_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic              neg_q_reg;
    logic              neg_r_reg;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg   <= '0;
            quo_reg   <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            dvs_reg   <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_q_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            neg_r_reg <= dividend[DATA_W-1];
        end
        else if (busy_reg) begin
            if (!diff[DATA_W]) begin
                rem_reg <= diff[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else begin
                rem_reg <= shifted[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;

endmodule

// ===== hdl/smx_ctrl.sv =====
// Controller state machine: sequences check, operand reads, execution and write-back.
module smx_ctrl
    import smx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    output logic     result_valid,
    input  logic     result_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_READ, S_EXEC, S_DIV, S_WRITE, S_DONE
    } state_t;

    state_t     state_reg;
    logic [1:0] cnt_reg;
    logic       result_valid_reg;
    logic       out_free;

    assign out_free     = !result_valid_reg || result_ready;
    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;

    always_comb begin
        cmd           = '0;
        cmd.rd_k      = cnt_reg;
        cmd.cap_k     = cnt_reg - 2'd1;
        cmd.wr_k      = cnt_reg;
        unique case (state_reg)
            S_IDLE:  cmd.load = item_valid;
            S_CHECK: cmd.check = 1'b1;
            S_READ:
            begin
                cmd.rd_en  = (cnt_reg < stat.need);
                cmd.cap_en = (cnt_reg != 2'd0);
            end
            S_EXEC:
            begin
                cmd.exec      = 1'b1;
                cmd.div_start = stat.div_go;
            end
            S_DIV:   cmd.div_take = stat.div_done;
            S_WRITE: cmd.wr_en = (cnt_reg < stat.nw);
            S_DONE:  cmd.load_out = out_free;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else begin
            // A new result takes the output register as the old one leaves it.
            if (state_reg == S_DONE && out_free) begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready) begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid) begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    cnt_reg <= '0;
                    if (stat.pre_err) begin
                        state_reg <= S_DONE;
                    end
                    else if (stat.need == 2'd0) begin
                        state_reg <= S_EXEC;
                    end
                    else begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (cnt_reg == stat.need) begin
                        state_reg <= S_EXEC;
                    end
                    else begin
                        cnt_reg <= cnt_reg + 2'd1;
                    end
                end
                S_EXEC:
                begin
                    cnt_reg   <= '0;
                    state_reg <= stat.div_go ? S_DIV : S_WRITE;
                end
                S_DIV:
                begin
                    if (stat.div_done) begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (cnt_reg < stat.nw) begin
                        cnt_reg <= cnt_reg + 2'd1;
                    end
                    else begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/smx_dp.sv =====
// Datapath: stack memory, variable store, operand registers, ALU and result registers.
module smx_dp
    import smx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [4:0]        opcode,
    input  logic [DATA_W-1:0] literal,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    output logic [2:0]        status,
    output logic              print_valid,
    output logic [DATA_W-1:0] print_value,
    output logic [6:0]        stack_depth
);

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] var_mem [VAR_COUNT];
    logic [VAR_COUNT-1:0] def_reg;

    logic [4:0]        op_reg;
    logic [DATA_W-1:0] lit_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [DATA_W-1:0] opd_reg [3];
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] var_rd_reg;
    logic [DATA_W-1:0] res_reg;
    status_t           status_reg;
    logic              pvalid_reg;
    logic [DATA_W-1:0] pval_reg;
    logic [SP_W-1:0]   wb_reg;
    logic [1:0]        nw_reg;

    logic [2:0]        out_status_reg;
    logic              out_pvalid_reg;
    logic [DATA_W-1:0] out_pval_reg;
    logic [6:0]        out_depth_reg;

    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] l_val;
    logic [DATA_W-1:0] a_val;
    logic [VI_W-1:0]   vidx;
    logic              bad_idx;
    status_t           pre_status;
    status_t           ex_status;
    logic [1:0]        ex_pop;
    logic [1:0]        ex_nw;
    logic [DATA_W-1:0] ex_res;
    logic              ex_var_we;
    logic              ex_def_set;
    logic              ex_print;
    logic [SP_W-1:0]   rd_addr_full;
    logic [SP_W-1:0]   wr_addr_full;
    logic [DATA_W-1:0] wr_val;
    logic [DATA_W-1:0] div_q;
    logic [DATA_W-1:0] div_r;
    logic              div_done;
    logic [SP_W+6:0]   depth_ext;

    assign r_val   = opd_reg[0];
    assign l_val   = opd_reg[1];
    assign a_val   = opd_reg[2];
    assign vidx    = r_val[VI_W-1:0];
    assign bad_idx = (r_val >= DATA_W'(VAR_COUNT));

    smx_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (l_val),
        .divisor   (r_val),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Checks that need only the opcode and the stack pointer.
    always_comb begin
        if (op_reg > OP_NOT) begin
            pre_status = ST_BADOP;
        end
        else if (sp_reg < SP_W'(op_need(op_reg))) begin
            pre_status = ST_UNDER;
        end
        else if ((op_reg == OP_PUSH || op_reg == OP_DUP) && sp_reg >= SP_W'(STACK_DEPTH)) begin
            pre_status = ST_OVER;
        end
        else begin
            pre_status = ST_OK;
        end
    end

    always_comb begin
        ex_status  = ST_OK;
        ex_pop     = 2'd2;
        ex_nw      = 2'd1;
        ex_res     = '0;
        ex_var_we  = 1'b0;
        ex_def_set = 1'b0;
        ex_print   = 1'b0;
        unique case (op_reg)
            OP_PUSH, OP_DUP:
            begin
                ex_pop = 2'd0;
            end
            OP_DROP:
            begin
                ex_pop = 2'd1;
                ex_nw  = 2'd0;
            end
            OP_PRINT:
            begin
                ex_pop   = 2'd1;
                ex_nw    = 2'd0;
                ex_print = 1'b1;
            end
            OP_NEG:
            begin
                ex_pop = 2'd1;
                ex_res = '0 - r_val;
            end
            OP_NOT:
            begin
                ex_pop = 2'd1;
                ex_res = DATA_W'(r_val == '0);
            end
            OP_SWAP: ex_nw = 2'd2;
            OP_ROT:
            begin
                ex_pop = 2'd3;
                ex_nw  = 2'd3;
            end
            OP_SET:
            begin
                ex_nw = 2'd0;
                if (bad_idx) begin
                    ex_status = ST_BADIDX;
                end
                else if (def_reg[vidx]) begin
                    ex_status = ST_EXISTS;
                end
                else begin
                    ex_var_we  = 1'b1;
                    ex_def_set = 1'b1;
                end
            end
            OP_FETCH:
            begin
                ex_pop = 2'd1;
                if (bad_idx) begin
                    ex_status = ST_BADIDX;
                    ex_nw     = 2'd0;
                end
                else if (!def_reg[vidx]) begin
                    ex_status = ST_UNDEF;
                    ex_nw     = 2'd0;
                end
            end
            OP_STORE:
            begin
                ex_nw = 2'd0;
                if (bad_idx) begin
                    ex_status = ST_BADIDX;
                end
                else if (!def_reg[vidx]) begin
                    ex_status = ST_UNDEF;
                end
                else begin
                    ex_var_we = 1'b1;
                end
            end
            OP_DIV, OP_MOD:
            begin
                if (r_val == '0) begin
                    ex_status = ST_DIVZ;
                    ex_pop    = 2'd0;
                    ex_nw     = 2'd0;
                end
            end
            OP_ADD: ex_res = l_val + r_val;
            OP_SUB: ex_res = l_val - r_val;
            OP_MUL: ex_res = l_val * r_val;
            OP_LT:  ex_res = DATA_W'($signed(l_val) < $signed(r_val));
            OP_GT:  ex_res = DATA_W'($signed(l_val) > $signed(r_val));
            OP_LE:  ex_res = DATA_W'($signed(l_val) <= $signed(r_val));
            OP_GE:  ex_res = DATA_W'($signed(l_val) >= $signed(r_val));
            OP_EQ:  ex_res = DATA_W'(l_val == r_val);
            OP_NE:  ex_res = DATA_W'(l_val != r_val);
            OP_AND: ex_res = DATA_W'(l_val != '0 && r_val != '0);
            OP_OR:  ex_res = DATA_W'(l_val != '0 || r_val != '0);
            default: ex_nw = 2'd0;
        endcase
    end

    always_comb begin
        unique case (op_reg)
            OP_PUSH:  wr_val = lit_reg;
            OP_DUP:   wr_val = r_val;
            OP_SWAP:  wr_val = (cmd.wr_k == 2'd0) ? r_val : l_val;
            OP_ROT:
            begin
                if (cmd.wr_k == 2'd0) begin
                    wr_val = l_val;
                end
                else if (cmd.wr_k == 2'd1) begin
                    wr_val = r_val;
                end
                else begin
                    wr_val = a_val;
                end
            end
            OP_FETCH: wr_val = var_rd_reg;
            default:  wr_val = res_reg;
        endcase
    end

    assign rd_addr_full = sp_reg - SP_W'(1) - SP_W'(cmd.rd_k);
    assign wr_addr_full = wb_reg + SP_W'(cmd.wr_k);

    always_ff @(posedge clk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= stack_mem[rd_addr_full[SA_W-1:0]];
        end
        if (cmd.wr_en) begin
            stack_mem[wr_addr_full[SA_W-1:0]] <= wr_val;
        end
    end

    always_ff @(posedge clk) begin
        var_rd_reg <= var_mem[vidx];
        if (cmd.exec && ex_var_we) begin
            var_mem[vidx] <= l_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sp_reg  <= '0;
            def_reg <= '0;
        end
        else if (cmd.exec) begin
            sp_reg <= sp_reg - SP_W'(ex_pop) + SP_W'(ex_nw);
            if (ex_def_set) begin
                def_reg[vidx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            op_reg  <= opcode;
            lit_reg <= literal;
        end
        if (cmd.cap_en) begin
            opd_reg[cmd.cap_k] <= rd_data_reg;
        end
        if (cmd.check) begin
            status_reg <= pre_status;
            pvalid_reg <= 1'b0;
            pval_reg   <= '0;
        end
        if (cmd.exec) begin
            status_reg <= ex_status;
            res_reg    <= ex_res;
            wb_reg     <= sp_reg - SP_W'(ex_pop);
            nw_reg     <= ex_nw;
            pvalid_reg <= ex_print;
            pval_reg   <= ex_print ? r_val : '0;
        end
        if (cmd.div_take) begin
            res_reg <= (op_reg == OP_DIV) ? div_q : div_r;
        end
        if (cmd.load_out) begin
            out_status_reg <= status_reg;
            out_pvalid_reg <= pvalid_reg;
            out_pval_reg   <= pval_reg;
            out_depth_reg  <= depth_ext[6:0];
        end
    end

    assign depth_ext = {7'd0, sp_reg};

    assign stat.pre_err  = (pre_status != ST_OK);
    assign stat.need     = op_need(op_reg);
    assign stat.div_go   = (op_reg == OP_DIV || op_reg == OP_MOD) && (r_val != '0);
    assign stat.div_done = div_done;
    assign stat.nw       = nw_reg;

    assign status      = out_status_reg;
    assign print_valid = out_pvalid_reg;
    assign print_value = out_pval_reg;
    assign stack_depth = out_depth_reg;

endmodule

// ===== hdl/stack_machine_execute_unit.sv =====
// Top level of the Forth-style stack machine execute unit.
//
// Usage: each beat on the item channel carries an opcode and a 32-bit literal
// and produces exactly one beat on the result channel, in order, giving the
// status, any printed value and the stack depth after the operation.
// Items are handled one at a time. The controller first checks the opcode
// against the stack pointer, then reads the operands from the single-port
// stack memory one per cycle, executes, and writes the results back one per
// cycle, then loads the result register and returns to idle before the next
// beat is taken. Divide and modulo wait for the bit-serial divider between
// execution and write-back. Errors detected before the reads go straight
// from the check to the result register. The result register lets a new
// item be accepted while the previous result still waits; if the receiver
// stalls, the next result is held in the datapath while the controller waits
// until the register frees, and no further item is taken. Reset empties the
// stack and clears every variable's defined bit; stack and variable contents
// are undefined until written and need no clearing pass.
module stack_machine_execute_unit
    import smx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    smx_in_if.sink   item,
    smx_out_if.source result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencing lives in the controller; all storage and arithmetic in the datapath.
    smx_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    smx_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .opcode      (item.opcode),
        .literal     (item.literal),
        .cmd         (cmd),
        .stat        (stat),
        .status      (result.status),
        .print_valid (result.print_valid),
        .print_value (result.print_value),
        .stack_depth (result.stack_depth)
    );

endmodule

// ===== hdl/smx_checker.sv =====
// Port-level checker of the stack machine execute unit and its bind.
`include "stack_machine_execute_unit_assert.svh"
module smx_port_checker
    import smx_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [2:0] result_status,
    input logic       result_print_valid,
    input logic [6:0] result_stack_depth
);

    `SMX_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid)
    `SMX_ASSERT_NEXT(a_one_at_a_time, item_valid && item_ready, !item_ready)
    `SMX_ASSERT_NOW(a_print_ok, result_valid && result_print_valid, result_status == ST_OK)
    `SMX_ASSERT_NOW(a_depth_range, result_valid, result_stack_depth <= 7'(STACK_DEPTH))

endmodule

bind stack_machine_execute_unit smx_port_checker u_smx_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item.valid),
    .item_ready         (item.ready),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_status      (result.status),
    .result_print_valid (result.print_valid),
    .result_stack_depth (result.stack_depth)
);

// ===== verif/smx_tb_if.sv =====
// Testbench-side copies of the item and result channel interfaces are not needed; this file holds the channel monitor types.
package smx_tb_pkg;
    import smx_pkg::*;

    // One expected or observed result beat.
    typedef struct packed {
        status_t     status;
        logic        print_valid;
        logic [31:0] print_value;
        logic [6:0]  stack_depth;
    } smx_result_t;
endpackage

// ===== verif/smx_checker.sv =====
// Checker that predicts the stack machine results from accepted beats and compares them.
module smx_checker
    import smx_pkg::*;
    import smx_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    smx_in_if           item,
    smx_out_if          result,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    localparam int EXP_DEPTH = 64;

    logic [31:0] stack_mem [STACK_DEPTH];
    int          sp;
    logic [31:0] var_val [VAR_COUNT];
    logic        var_def [VAR_COUNT];
    smx_result_t exp_mem [EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;

    assign pending = exp_wr - exp_rd;

    function automatic logic [31:0] peek(input int k);
        return stack_mem[sp - 1 - k];
    endfunction

    function automatic void push_word(input logic [31:0] v);
        stack_mem[sp] = v;
        sp++;
    endfunction

    // Work out the result of one operation and update the model state.
    function automatic smx_result_t execute_op(input logic [4:0] op, input logic [31:0] lit);
        smx_result_t r;
        int          need;
        logic [31:0] rv;
        logic [31:0] lv;
        logic [31:0] av;
        logic [31:0] res;
        r = '0;
        r.status = ST_OK;
        rv = '0;
        lv = '0;
        res = '0;
        if (op > OP_NOT) begin
            r.status = ST_BADOP;
        end
        else begin
            case (op)
                OP_PUSH: need = 0;
                OP_NEG, OP_PRINT, OP_DUP, OP_DROP, OP_FETCH, OP_NOT: need = 1;
                OP_ROT: need = 3;
                default: need = 2;
            endcase
            if (sp < need) r.status = ST_UNDER;
            else if ((op == OP_PUSH || op == OP_DUP) && sp >= STACK_DEPTH) r.status = ST_OVER;
            else if ((op == OP_DIV || op == OP_MOD) && peek(0) == 0) r.status = ST_DIVZ;
            else begin
                if (need >= 1) rv = peek(0);
                if (need >= 2) lv = peek(1);
                case (op)
                    OP_PUSH: push_word(lit);
                    OP_DUP: push_word(rv);
                    OP_DROP: sp--;
                    OP_NEG: begin sp--; push_word(-rv); end
                    OP_PRINT:
                    begin
                        sp--;
                        r.print_valid = 1'b1;
                        r.print_value = rv;
                    end
                    OP_SWAP: begin sp -= 2; push_word(rv); push_word(lv); end
                    OP_ROT:
                    begin
                        av = peek(2);
                        sp -= 3;
                        push_word(lv);
                        push_word(rv);
                        push_word(av);
                    end
                    OP_SET:
                    begin
                        sp -= 2;
                        if (rv >= VAR_COUNT) r.status = ST_BADIDX;
                        else if (var_def[rv]) r.status = ST_EXISTS;
                        else begin var_val[rv] = lv; var_def[rv] = 1'b1; end
                    end
                    OP_FETCH:
                    begin
                        sp--;
                        if (rv >= VAR_COUNT) r.status = ST_BADIDX;
                        else if (!var_def[rv]) r.status = ST_UNDEF;
                        else push_word(var_val[rv]);
                    end
                    OP_STORE:
                    begin
                        sp -= 2;
                        if (rv >= VAR_COUNT) r.status = ST_BADIDX;
                        else if (!var_def[rv]) r.status = ST_UNDEF;
                        else var_val[rv] = lv;
                    end
                    OP_NOT: begin sp--; push_word({31'd0, rv == 0}); end
                    default:
                    begin
                        case (op)
                            OP_ADD: res = lv + rv;
                            OP_SUB: res = lv - rv;
                            OP_MUL: res = lv * rv;
                            OP_DIV:
                            begin
                                // The most negative value over minus one wraps to itself.
                                if (lv == 32'h8000_0000 && rv == 32'hFFFF_FFFF) res = lv;
                                else res = $signed(lv) / $signed(rv);
                            end
                            OP_MOD:
                            begin
                                if (lv == 32'h8000_0000 && rv == 32'hFFFF_FFFF) res = '0;
                                else res = $signed(lv) % $signed(rv);
                            end
                            OP_LT: res = {31'd0, $signed(lv) < $signed(rv)};
                            OP_GT: res = {31'd0, $signed(lv) > $signed(rv)};
                            OP_LE: res = {31'd0, $signed(lv) <= $signed(rv)};
                            OP_GE: res = {31'd0, $signed(lv) >= $signed(rv)};
                            OP_EQ: res = {31'd0, lv == rv};
                            OP_NE: res = {31'd0, lv != rv};
                            OP_AND: res = {31'd0, lv != 0 && rv != 0};
                            default: res = {31'd0, lv != 0 || rv != 0};
                        endcase
                        sp -= 2;
                        push_word(res);
                    end
                endcase
            end
        end
        r.stack_depth = sp[6:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        smx_result_t seen;
        smx_result_t want;
        if (!rst_n) begin
            sp = 0;
            for (int i = 0; i < VAR_COUNT; i++) var_def[i] = 1'b0;
            exp_wr = 0;
            exp_rd = 0;
            fail_count <= 0;
            results_seen <= 0;
        end
        else begin
            if (item.valid && item.ready) begin
                exp_mem[exp_wr % EXP_DEPTH] = execute_op(item.opcode, item.literal);
                exp_wr++;
            end
            if (result.valid && result.ready) begin
                results_seen <= results_seen + 1;
                seen.status = status_t'(result.status);
                seen.print_valid = result.print_valid;
                seen.print_value = result.print_value;
                seen.stack_depth = result.stack_depth;
                if (exp_wr == exp_rd) begin
                    if (fail_count < 10) $display("Result beat with nothing expected: %p", seen);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (seen !== want) begin
                        if (fail_count < 10)
                            $display("Mismatch: expected %p, got %p", want, seen);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== verif/tb_top.sv =====
// Top of the stack machine testbench: clock, reset, stimulus and verdict.
module tb_top;
    import smx_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   results_seen;
    int   tb_depth;      // Stimulus-side view of the stack depth.
    int   idle_pct;      // Chance in a hundred that the sender idles.
    int   stall_pct;     // Chance in a hundred that the receiver stalls.
    int   quiet_cycles = 0;
    int   sent;

    smx_in_if  item_ch ();
    smx_out_if result_ch ();

    stack_machine_execute_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    smx_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item_ch),
        .result       (result_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) result_ch.ready <= 1'b0;
        else result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: counts cycles in which no beat moves on either channel.
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("Watchdog expired with %0d results outstanding", pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Present one beat and hold it until it is accepted. The stack depth is
    // tracked loosely so that random stimulus stays mostly well formed.
    task automatic send_beat(input logic [4:0] op, input logic [31:0] lit);
        while ($urandom_range(99) < idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.opcode  <= op;
        item_ch.literal <= lit;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        sent++;
        if (op == OP_PUSH || op == OP_DUP) begin
            if (tb_depth < STACK_DEPTH) tb_depth++;
        end
        else if (op <= OP_NOT && op != OP_SWAP && op != OP_ROT) begin
            if (op == OP_NEG) tb_depth = tb_depth;
            else if (op == OP_FETCH || op == OP_NOT) tb_depth = tb_depth;
            else if (op == OP_PRINT || op == OP_DROP) tb_depth -= (tb_depth > 0);
            else if (tb_depth >= 2) tb_depth -= (op == OP_SET || op == OP_STORE) ? 2 : 1;
        end
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(20);
            default: return $urandom;
        endcase
    endfunction

    // Random step: a push, an index for variable ops, or another opcode.
    task automatic random_step();
        int pick;
        logic [4:0] op;
        pick = $urandom_range(99);
        if (pick < 3) send_beat(5'($urandom_range(31, 24)), $urandom);
        else if (pick < 12) begin
            // Variable access: push a value and a likely index, then the op.
            send_beat(OP_PUSH, rand_word());
            send_beat(OP_PUSH, ($urandom_range(9) == 0) ? rand_word() : $urandom_range(15));
            case ($urandom_range(2))
                0: op = OP_SET;
                1: op = OP_STORE;
                default: op = OP_FETCH;
            endcase
            send_beat(op, $urandom);
        end
        else if (tb_depth < 3 || (tb_depth < 60 && pick < 45)) send_beat(OP_PUSH, rand_word());
        else send_beat(5'($urandom_range(OP_NOT, OP_ADD)), $urandom);
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.opcode  = '0;
        item_ch.literal = '0;
        idle_pct  = 0;
        stall_pct = 0;
        tb_depth  = 0;
        sent      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: underflow on an empty stack, a bad opcode, extremes,
        // most negative over minus one, divide by zero and the variable cases.
        send_beat(OP_ADD, 32'hFFFF_FFFF);
        send_beat(OP_FETCH, '0);
        send_beat(5'd31, 32'h1234_5678);
        send_beat(OP_PUSH, 32'h8000_0000);
        send_beat(OP_DUP, '0);
        send_beat(OP_NEG, '0);
        send_beat(OP_PUSH, 32'hFFFF_FFFF);
        send_beat(OP_DIV, '0);
        send_beat(OP_PUSH, 32'h8000_0000);
        send_beat(OP_PUSH, 32'hFFFF_FFFF);
        send_beat(OP_MOD, '0);
        send_beat(OP_PUSH, '0);
        send_beat(OP_DIV, '0);
        send_beat(OP_PUSH, 32'h7FFF_FFFF);
        send_beat(OP_PUSH, 32'd3);
        send_beat(OP_SET, '0);
        send_beat(OP_PUSH, 32'd3);
        send_beat(OP_PUSH, 32'd3);
        send_beat(OP_SET, '0);
        send_beat(OP_PUSH, 32'd5);
        send_beat(OP_FETCH, '0);
        send_beat(OP_PUSH, 32'hFFFF_FFFF);
        send_beat(OP_FETCH, '0);
        send_beat(OP_ROT, '0);
        send_beat(OP_PRINT, '0);
        wait_drained();

        // Fill the stack to overflow, then empty it again.
        for (int i = 0; i < STACK_DEPTH + 1; i++) send_beat(OP_PUSH, $urandom);
        send_beat(OP_DUP, '0);
        for (int i = 0; i < STACK_DEPTH; i++) send_beat(OP_PRINT, '0);
        tb_depth = 0;

        // Random phases with different idling, each ended by a full drain.
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = (phase == 1 || phase == 3) ? 76 : 0;
            stall_pct = (phase == 2) ? 76 : 0;
            if (phase == 3) begin
                idle_pct  = 9;
                stall_pct = 9;
            end
            for (int n = 0; n < 95; n++) random_step();
            wait_drained();
        end

        $display("Covered %0d item beats and %0d result beats over four idling phases,",
                 sent, results_seen);
        $display("including stack overflow, underflow, variables and divide corner cases.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
